// ===== rtl/lsrp_pkg.sv =====
`default_nettype none

package lsrp_pkg;

    // default table and stack sizes
    localparam int DEF_NUM_STATES      = 128;
    localparam int DEF_NUM_SYMBOLS     = 64;
    localparam int DEF_NUM_PRODUCTIONS = 128;
    localparam int DEF_STACK_DEPTH     = 256;
    localparam int DEF_MAX_RHS         = 63;
    localparam int DEF_REDUCE_LIMIT    = 63;

    // depth of the command queue between front and back
    localparam int CMD_Q_DEPTH = 4;

    // input opcodes carried in tuser
    typedef enum logic [2:0] {
        OP_LOAD_ACT  = 3'd0,
        OP_LOAD_GOTO = 3'd1,
        OP_LOAD_PROD = 3'd2,
        OP_START     = 3'd3,
        OP_TOKEN     = 3'd4
    } t_opcode;

    // action table entry kinds
    typedef enum logic [1:0] {
        AK_EMPTY  = 2'd0,
        AK_SHIFT  = 2'd1,
        AK_REDUCE = 2'd2,
        AK_ACCEPT = 2'd3
    } t_act_kind;

    // reported step kinds
    typedef enum logic [2:0] {
        STEP_SHIFT    = 3'd0,
        STEP_REDUCE   = 3'd1,
        STEP_ACCEPT   = 3'd2,
        STEP_NO_ACT   = 3'd3,
        STEP_NO_GOTO  = 3'd4,
        STEP_OVERFLOW = 3'd5,
        STEP_LIMIT    = 3'd6,
        STEP_INACTIVE = 3'd7
    } t_step;

    // classified command kinds in the queue
    typedef enum logic [2:0] {
        CMD_LOAD_ACT,
        CMD_LOAD_GOTO,
        CMD_LOAD_PROD,
        CMD_START,
        CMD_TOKEN
    } t_cmd_kind;

    // back end sequencer states
    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_ACT,
        BK_PROD,
        BK_POP,
        BK_GOTO
    } t_back_state;

    // one queued command
    typedef struct packed {
        t_cmd_kind   kind;
        logic [6:0]  row;
        logic [5:0]  sym;
        logic        sym_ok;
        logic [6:0]  prod;
        logic [8:0]  act_word;   // kind, arg
        logic [7:0]  goto_word;  // valid, target
        logic [11:0] prod_word;  // left symbol, clamped length
    } t_cmd_entry;

    localparam int CMD_W = $bits(t_cmd_entry);

endpackage

`default_nettype wire

// ===== rtl/lr_shift_reduce_parse_engine.sv =====
// Table-driven LR shift-reduce parser. After reset the engine sweeps the action and goto
// tables to empty, one entry per cycle (NUM_STATES*NUM_SYMBOLS entries, 8192 by default),
// and takes no beat until that pass is done. Loads and starts are queued. A token starts
// with an action read and ends in a shift, accept or error, with a production read, stack
// read, goto read and new action read for every reduce (each a registered memory port in
// the back end); a token that arrives while no parse runs retires with an inactive beat.
// Any cycle that would produce a result beat waits while the output register is still full.
// A 4-entry command queue lets input beats keep arriving while a token is still reducing,
// and one output register holds a result beat until it is taken.
`default_nettype none

module lr_shift_reduce_parse_engine
    import lsrp_pkg::*;
#(
    parameter int NUM_STATES      = DEF_NUM_STATES,
    parameter int NUM_SYMBOLS     = DEF_NUM_SYMBOLS,
    parameter int NUM_PRODUCTIONS = DEF_NUM_PRODUCTIONS,
    parameter int STACK_DEPTH     = DEF_STACK_DEPTH,
    parameter int MAX_RHS         = DEF_MAX_RHS,
    parameter int REDUCE_LIMIT    = DEF_REDUCE_LIMIT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // state_row, symbol_index, prod_index, action_kind, action_arg, goto_valid,
    // goto_target, rhs_length, zero pad
    input  wire logic [47:0] i_s_axis_tdata,
    // opcode
    input  wire logic [2:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // step_kind, push_state, reduced_production, stack_depth, zero pad
    output logic [31:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast
);

    logic             clr_done;
    logic             q_push;
    t_cmd_entry       front_entry;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    logic [CMD_W-1:0] q_data;

    // input classification
    lsrp_front #(
        .NUM_STATES      (NUM_STATES),
        .NUM_SYMBOLS     (NUM_SYMBOLS),
        .NUM_PRODUCTIONS (NUM_PRODUCTIONS),
        .MAX_RHS         (MAX_RHS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_run           (clr_done),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_push          (q_push),
        .o_entry         (front_entry),
        .i_full          (q_full)
    );

    // command queue
    lsrp_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_valid (q_valid)
    );

    // table walk and result generation
    lsrp_back #(
        .NUM_STATES      (NUM_STATES),
        .NUM_SYMBOLS     (NUM_SYMBOLS),
        .NUM_PRODUCTIONS (NUM_PRODUCTIONS),
        .STACK_DEPTH     (STACK_DEPTH),
        .REDUCE_LIMIT    (REDUCE_LIMIT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .o_clr_done      (clr_done),
        .i_q_valid       (q_valid),
        .i_q_entry       (t_cmd_entry'(q_data)),
        .o_q_pop         (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

`ifndef SYNTHESIS
    // no beat is taken or produced while the tables are being cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !clr_done |-> (!o_s_axis_tready && !o_m_axis_tvalid))
        else $error("activity during table clear");

    // the clearing pass runs once
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_done |=> clr_done)
        else $error("table clear restarted");

    // the front never offers a beat the queue cannot hold
    a_no_lost_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    // the back never pops an empty queue
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("command popped from empty queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/lsrp_front.sv =====
`default_nettype none

module lsrp_front
    import lsrp_pkg::*;
#(
    parameter int NUM_STATES      = DEF_NUM_STATES,
    parameter int NUM_SYMBOLS     = DEF_NUM_SYMBOLS,
    parameter int NUM_PRODUCTIONS = DEF_NUM_PRODUCTIONS,
    parameter int MAX_RHS         = DEF_MAX_RHS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_run,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,
    input  wire logic [2:0]  i_s_axis_tuser,
    output logic             o_push,
    output t_cmd_entry       o_entry,
    input  wire logic        i_full
);

    logic        r_valid;
    t_cmd_entry  r_entry;
    logic        c_keep;
    t_cmd_entry  c_entry;
    logic        row_ok;
    logic        sym_ok;
    logic [5:0]  rlen;
    logic        accept;

    // field unpacking and range checks
    always_comb begin
        row_ok = int'(i_s_axis_tdata[6:0]) < NUM_STATES;
        sym_ok = int'(i_s_axis_tdata[12:7]) < NUM_SYMBOLS;
        rlen   = i_s_axis_tdata[42:37];
        if (int'(rlen) > MAX_RHS) begin
            rlen = 6'(MAX_RHS);
        end
        c_entry.kind      = CMD_START;
        c_entry.row       = i_s_axis_tdata[6:0];
        c_entry.sym       = i_s_axis_tdata[12:7];
        c_entry.sym_ok    = sym_ok;
        c_entry.prod      = i_s_axis_tdata[19:13];
        c_entry.act_word  = {i_s_axis_tdata[21:20], i_s_axis_tdata[28:22]};
        c_entry.goto_word = {i_s_axis_tdata[29], i_s_axis_tdata[36:30]};
        c_entry.prod_word = {i_s_axis_tdata[12:7], rlen};
        c_keep            = 1'b0;
        case (t_opcode'(i_s_axis_tuser))
            OP_LOAD_ACT: begin
                c_entry.kind = CMD_LOAD_ACT;
                c_keep       = row_ok && sym_ok;
            end
            OP_LOAD_GOTO: begin
                c_entry.kind = CMD_LOAD_GOTO;
                c_keep       = row_ok && sym_ok;
            end
            OP_LOAD_PROD: begin
                c_entry.kind = CMD_LOAD_PROD;
                c_keep       = int'(i_s_axis_tdata[19:13]) < NUM_PRODUCTIONS;
            end
            OP_START: begin
                c_entry.kind = CMD_START;
                c_keep       = 1'b1;
            end
            OP_TOKEN: begin
                c_entry.kind = CMD_TOKEN;
                c_keep       = 1'b1;
            end
            default: begin
                c_keep = 1'b0;
            end
        endcase
    end

    // handshake: hold one classified beat until the queue takes it
    assign o_push          = r_valid && !i_full;
    assign o_s_axis_tready = i_run && (!r_valid || !i_full);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_entry         = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= c_keep;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= c_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lsrp_fifo.sv =====
`default_nettype none

module lsrp_fifo
    import lsrp_pkg::*;
#(
    parameter int WIDTH = CMD_W,
    parameter int DEPTH = CMD_Q_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lsrp_back.sv =====
`default_nettype none

module lsrp_back
    import lsrp_pkg::*;
#(
    parameter int NUM_STATES      = DEF_NUM_STATES,
    parameter int NUM_SYMBOLS     = DEF_NUM_SYMBOLS,
    parameter int NUM_PRODUCTIONS = DEF_NUM_PRODUCTIONS,
    parameter int STACK_DEPTH     = DEF_STACK_DEPTH,
    parameter int REDUCE_LIMIT    = DEF_REDUCE_LIMIT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    output logic             o_clr_done,
    input  wire logic        i_q_valid,
    input  wire t_cmd_entry  i_q_entry,
    output logic             o_q_pop,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast
);

    localparam int TAB_CELLS = NUM_STATES * NUM_SYMBOLS;
    localparam int TAB_AW    = $clog2(TAB_CELLS);
    localparam int PROD_AW   = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1;
    localparam int SP_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W     = $clog2(REDUCE_LIMIT + 1);

    // table and stack memories
    logic [8:0]  action_mem [TAB_CELLS];
    logic [7:0]  goto_mem   [TAB_CELLS];
    logic [11:0] prod_mem   [NUM_PRODUCTIONS];
    logic [6:0]  stack_mem  [STACK_DEPTH];

    t_back_state       r_state, n_state;
    logic              r_active, n_active;
    logic [SP_W-1:0]   r_top, n_top;
    logic [6:0]        r_top_state, n_top_state;
    logic [5:0]        r_sym, n_sym;
    logic              r_sym_ok, n_sym_ok;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [6:0]        r_arg, n_arg;
    logic [5:0]        r_left, n_left;
    logic              r_act_hit, n_act_hit;
    logic              r_goto_hit, n_goto_hit;
    logic [TAB_AW-1:0] r_clr, n_clr;

    logic [8:0]        r_act_rdata;
    logic [7:0]        r_goto_rdata;
    logic [11:0]       r_prod_rdata;
    logic [6:0]        r_stk_rdata;

    logic              act_we, act_re;
    logic [TAB_AW-1:0] act_waddr, act_raddr;
    logic [8:0]        act_wdata;
    logic              goto_we, goto_re;
    logic [TAB_AW-1:0] goto_waddr, goto_raddr;
    logic [7:0]        goto_wdata;
    logic              prod_we, prod_re;
    logic [PROD_AW-1:0] prod_waddr, prod_raddr;
    logic              stk_we, stk_re;
    logic [SP_W-1:0]   stk_waddr, stk_raddr;
    logic [6:0]        stk_wdata;

    logic              emit;
    t_step             e_kind;
    logic [6:0]        e_state;
    logic [6:0]        e_prod;
    logic [8:0]        e_depth;
    logic              e_last;

    logic              r_out_valid;
    t_step             r_out_kind;
    logic [6:0]        r_out_state;
    logic [6:0]        r_out_prod;
    logic [8:0]        r_out_depth;
    logic              r_out_last;

    logic              out_free;
    t_act_kind         act_kind;
    logic [6:0]        act_arg;
    logic              top_full;
    logic [SP_W-1:0]   top_inc;
    logic [5:0]        rhs_len;
    logic [6:0]        exposed;
    logic              goto_ok;

    function automatic logic [TAB_AW-1:0] f_tab(input logic [6:0] st, input logic [5:0] sy);
        f_tab = TAB_AW'(int'(st) * NUM_SYMBOLS + int'(sy));
    endfunction

    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign o_clr_done = r_state != BK_CLEAR;
    assign act_kind   = r_act_hit ? t_act_kind'(r_act_rdata[8:7]) : AK_EMPTY;
    assign act_arg    = r_act_rdata[6:0];
    assign top_full   = r_top == SP_W'(STACK_DEPTH - 1);
    assign top_inc    = r_top + 1'b1;
    assign rhs_len    = r_prod_rdata[5:0];
    assign exposed    = r_stk_rdata;
    assign goto_ok    = r_goto_hit && r_goto_rdata[7];

    // sequencer: next state, memory controls and result beats
    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_top       = r_top;
        n_top_state = r_top_state;
        n_sym       = r_sym;
        n_sym_ok    = r_sym_ok;
        n_n         = r_n;
        n_arg       = r_arg;
        n_left      = r_left;
        n_act_hit   = r_act_hit;
        n_goto_hit  = r_goto_hit;
        n_clr       = r_clr;
        o_q_pop     = 1'b0;
        act_we      = 1'b0;
        act_re      = 1'b0;
        act_waddr   = f_tab(i_q_entry.row, i_q_entry.sym);
        act_raddr   = f_tab(r_top_state, r_sym);
        act_wdata   = i_q_entry.act_word;
        goto_we     = 1'b0;
        goto_re     = 1'b0;
        goto_waddr  = f_tab(i_q_entry.row, i_q_entry.sym);
        goto_raddr  = f_tab(exposed, r_left);
        goto_wdata  = i_q_entry.goto_word;
        prod_we     = 1'b0;
        prod_re     = 1'b0;
        prod_waddr  = PROD_AW'(i_q_entry.prod);
        prod_raddr  = PROD_AW'(act_arg);
        stk_we      = 1'b0;
        stk_re      = 1'b0;
        stk_waddr   = top_inc;
        stk_raddr   = r_top;
        stk_wdata   = act_arg;
        emit        = 1'b0;
        e_kind      = STEP_NO_ACT;
        e_state     = r_top_state;
        e_prod      = '0;
        e_depth     = 9'(r_top);
        e_last      = 1'b1;
        case (r_state)
            // sweep both tables to empty after reset
            BK_CLEAR: begin
                act_we     = 1'b1;
                act_waddr  = r_clr;
                act_wdata  = '0;
                goto_we    = 1'b1;
                goto_waddr = r_clr;
                goto_wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == TAB_AW'(TAB_CELLS - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            // take the next queued command
            BK_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_entry.kind)
                        CMD_LOAD_ACT: begin
                            act_we  = 1'b1;
                            o_q_pop = 1'b1;
                        end
                        CMD_LOAD_GOTO: begin
                            goto_we = 1'b1;
                            o_q_pop = 1'b1;
                        end
                        CMD_LOAD_PROD: begin
                            prod_we = 1'b1;
                            o_q_pop = 1'b1;
                        end
                        CMD_START: begin
                            stk_we      = 1'b1;
                            stk_waddr   = '0;
                            stk_wdata   = '0;
                            n_top       = '0;
                            n_top_state = '0;
                            n_active    = 1'b1;
                            o_q_pop     = 1'b1;
                        end
                        CMD_TOKEN: begin
                            if (!r_active) begin
                                if (out_free) begin
                                    emit    = 1'b1;
                                    e_kind  = STEP_INACTIVE;
                                    e_state = '0;
                                    o_q_pop = 1'b1;
                                end
                            end else begin
                                o_q_pop   = 1'b1;
                                n_sym     = i_q_entry.sym;
                                n_sym_ok  = i_q_entry.sym_ok;
                                n_n       = '0;
                                act_raddr = f_tab(r_top_state, i_q_entry.sym);
                                n_act_hit = i_q_entry.sym_ok &&
                                            (int'(r_top_state) < NUM_STATES);
                                act_re    = n_act_hit;
                                n_state   = BK_ACT;
                            end
                        end
                        default: begin
                            o_q_pop = 1'b1;
                        end
                    endcase
                end
            end
            // act on the action entry for the top state
            BK_ACT: begin
                if (act_kind == AK_EMPTY ||
                    (act_kind == AK_REDUCE && int'(act_arg) >= NUM_PRODUCTIONS)) begin
                    if (out_free) begin
                        emit     = 1'b1;
                        e_kind   = STEP_NO_ACT;
                        n_active = 1'b0;
                        n_state  = BK_IDLE;
                    end
                end else if (act_kind == AK_ACCEPT) begin
                    if (out_free) begin
                        emit     = 1'b1;
                        e_kind   = STEP_ACCEPT;
                        n_active = 1'b0;
                        n_state  = BK_IDLE;
                    end
                end else if (act_kind == AK_SHIFT) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        n_state = BK_IDLE;
                        if (top_full) begin
                            e_kind   = STEP_OVERFLOW;
                            n_active = 1'b0;
                        end else begin
                            stk_we      = 1'b1;
                            n_top       = top_inc;
                            n_top_state = act_arg;
                            e_kind      = STEP_SHIFT;
                            e_state     = act_arg;
                            e_depth     = 9'(top_inc);
                        end
                    end
                end else begin
                    if (int'(r_n) >= REDUCE_LIMIT) begin
                        if (out_free) begin
                            emit     = 1'b1;
                            e_kind   = STEP_LIMIT;
                            n_active = 1'b0;
                            n_state  = BK_IDLE;
                        end
                    end else begin
                        prod_re = 1'b1;
                        n_arg   = act_arg;
                        n_state = BK_PROD;
                    end
                end
            end
            // pop by the right-side length, saturating at the bottom
            BK_PROD: begin
                n_left = r_prod_rdata[11:6];
                if (int'(rhs_len) >= int'(r_top)) begin
                    n_top = '0;
                end else begin
                    n_top = r_top - SP_W'(rhs_len);
                end
                stk_re    = 1'b1;
                stk_raddr = n_top;
                n_state   = BK_POP;
            end
            // look up goto for the exposed state
            BK_POP: begin
                n_goto_hit = (int'(exposed) < NUM_STATES) && (int'(r_left) < NUM_SYMBOLS);
                goto_re    = n_goto_hit;
                n_state    = BK_GOTO;
            end
            // push the goto state or end the parse
            BK_GOTO: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_state = exposed;
                    if (!goto_ok) begin
                        e_kind      = STEP_NO_GOTO;
                        e_prod      = r_arg;
                        n_active    = 1'b0;
                        n_top_state = exposed;
                        n_state     = BK_IDLE;
                    end else if (top_full) begin
                        e_kind      = STEP_OVERFLOW;
                        n_active    = 1'b0;
                        n_top_state = exposed;
                        n_state     = BK_IDLE;
                    end else begin
                        stk_we      = 1'b1;
                        stk_wdata   = r_goto_rdata[6:0];
                        n_top       = top_inc;
                        n_top_state = r_goto_rdata[6:0];
                        e_kind      = STEP_REDUCE;
                        e_state     = r_goto_rdata[6:0];
                        e_prod      = r_arg;
                        e_depth     = 9'(top_inc);
                        e_last      = 1'b0;
                        n_n         = r_n + 1'b1;
                        act_raddr   = f_tab(r_goto_rdata[6:0], r_sym);
                        n_act_hit   = r_sym_ok && (int'(r_goto_rdata[6:0]) < NUM_STATES);
                        act_re      = n_act_hit;
                        n_state     = BK_ACT;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_active    <= 1'b0;
            r_top       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_top    <= n_top;
            r_clr    <= n_clr;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_top_state <= n_top_state;
        r_sym       <= n_sym;
        r_sym_ok    <= n_sym_ok;
        r_n         <= n_n;
        r_arg       <= n_arg;
        r_left      <= n_left;
        r_act_hit   <= n_act_hit;
        r_goto_hit  <= n_goto_hit;
        if (emit) begin
            r_out_kind  <= e_kind;
            r_out_state <= e_state;
            r_out_prod  <= e_prod;
            r_out_depth <= e_depth;
            r_out_last  <= e_last;
        end
    end

    // action table port
    always_ff @(posedge i_clk) begin
        if (act_we) begin
            action_mem[act_waddr] <= act_wdata;
        end
        if (act_re) begin
            r_act_rdata <= action_mem[act_raddr];
        end
    end

    // goto table port
    always_ff @(posedge i_clk) begin
        if (goto_we) begin
            goto_mem[goto_waddr] <= goto_wdata;
        end
        if (goto_re) begin
            r_goto_rdata <= goto_mem[goto_raddr];
        end
    end

    // production table port
    always_ff @(posedge i_clk) begin
        if (prod_we) begin
            prod_mem[prod_waddr] <= i_q_entry.prod_word;
        end
        if (prod_re) begin
            r_prod_rdata <= prod_mem[prod_raddr];
        end
    end

    // state stack port
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stk_rdata <= stack_mem[stk_raddr];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_depth, r_out_prod, r_out_state, r_out_kind};
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire
